// File: hw/rtl/bffsa_pkg.sv
`default_nettype none
package bffsa_pkg;

    localparam int BYTES_W = 16;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int NEED_W  = 17;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_CLR     = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd1;
    localparam logic [ST_W-1:0] ST_DIV     = 4'd2;
    localparam logic [ST_W-1:0] ST_SRCH_RD = 4'd3;
    localparam logic [ST_W-1:0] ST_SRCH_EX = 4'd4;
    localparam logic [ST_W-1:0] ST_MARK_RD = 4'd5;
    localparam logic [ST_W-1:0] ST_MARK_WR = 4'd6;
    localparam logic [ST_W-1:0] ST_FDIV    = 4'd7;
    localparam logic [ST_W-1:0] ST_FFIX    = 4'd8;
    localparam logic [ST_W-1:0] ST_FREE_RD = 4'd9;
    localparam logic [ST_W-1:0] ST_FREE_WR = 4'd10;
    localparam logic [ST_W-1:0] ST_DONE    = 4'd11;

endpackage
`default_nettype wire

// File: hw/rtl/bffsa_div.sv
`default_nettype none
module bffsa_div #(
    parameter int DIVISOR = 4
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire [bffsa_pkg::BYTES_W-1:0]  i_dividend,
    output logic                          o_done,
    output logic [bffsa_pkg::NEED_W-1:0]  o_need
);
    import bffsa_pkg::*;

    // quotient by reciprocal multiplication, exact for every 16-bit dividend
    localparam int     SH    = BYTES_W + $clog2(DIVISOR);
    localparam int     MW    = BYTES_W + 1;
    localparam int     PW    = BYTES_W + MW;
    localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1))
                               / longint'(DIVISOR);
    localparam logic [MW-1:0]      RECIP_V = MW'(RECIP);
    localparam logic [BYTES_W-1:0] DIV_V   = BYTES_W'(DIVISOR);

    logic [BYTES_W-1:0] r_x;
    logic [BYTES_W-1:0] r_q;
    logic [NEED_W-1:0]  r_need;
    logic               r_v1;
    logic               r_v2;
    logic               r_done;
    logic [PW-1:0]      n_prod;
    logic [BYTES_W-1:0] n_q;
    logic [BYTES_W-1:0] n_back;

    always_comb begin
        n_prod = PW'(r_x) * PW'(RECIP_V);
        n_q    = BYTES_W'(n_prod >> SH);
        n_back = r_q * DIV_V;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
            if (i_start) begin
                r_x <= i_dividend;
            end
            if (r_v1) begin
                r_q <= n_q;
            end
            if (r_v2) begin
                r_need <= NEED_W'(r_q) + NEED_W'(n_back != r_x);
            end
        end
    end

    assign o_done = r_done;
    assign o_need = r_need;

endmodule
`default_nettype wire

// File: hw/rtl/bffsa_maps.sv
`default_nettype none
module bffsa_maps #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int W     = 32
) (
    input  wire           i_clk,
    input  wire  [AW-1:0] i_addr,
    input  wire           i_wr_en,
    input  wire  [W-1:0]  i_wr_free,
    input  wire  [W-1:0]  i_wr_cont,
    output logic [W-1:0]  o_rd_free,
    output logic [W-1:0]  o_rd_cont
);
    logic [W-1:0] r_free_mem [DEPTH];
    logic [W-1:0] r_cont_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_free_mem[i_addr] <= i_wr_free;
            r_cont_mem[i_addr] <= i_wr_cont;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_free <= r_free_mem[i_addr];
        o_rd_cont <= r_cont_mem[i_addr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_first_fit_slot_allocator.sv
`default_nettype none
// Slot allocator over a pool of SLOT_TOTAL slots held as two bitmaps (free and
// continuation) in a word-wide memory of ceil(SLOT_TOTAL/MAP_WORD_BITS) words.
// After reset the maps are cleared one word per cycle, so no beat is taken until
// the clear is done. An allocate beat first turns bytes into slots in the
// divider, then scans map words from word 0 up to the word where the run ends,
// then marks each word the run covers, from the last down, with a read and a
// write back. A free beat reads and writes back each word the freed run touches.
// The search only reads the words. One beat is worked at a time; the result
// waits in an output register and a new beat is taken while it waits.
module bitmap_first_fit_slot_allocator #(
    parameter int SLOT_TOTAL    = 1024,
    parameter int SLOT_BYTES    = 4,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // request_bytes, start_slot
    input  wire  [0:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata    // ok, granted_slot, slot_count
);
    import bffsa_pkg::*;

    localparam int W         = MAP_WORD_BITS;
    localparam int MAP_WORDS = (SLOT_TOTAL + W - 1) / W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW        = $clog2(SLOT_TOTAL + 1);
    localparam int BW        = $clog2(W);
    localparam int ZW        = $clog2(W + 1);
    localparam int LW        = CW + ZW;
    localparam int RECIP     = 65536 / W;
    localparam int PW        = SLOT_W + 14;

    logic [ST_W-1:0]    r_state;
    logic [SLOT_W-1:0]  r_slot;
    logic [AW-1:0]      r_w;
    logic [CW-1:0]      r_base;
    logic [LW-1:0]      r_run;
    logic [CW-1:0]      r_need;
    logic [CW-1:0]      r_start;
    logic [CW-1:0]      r_end;
    logic [BW-1:0]      r_b0;
    logic               r_first;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_q;
    logic               r_res_ok;
    logic [CW-1:0]      r_res_slot;
    logic [CW-1:0]      r_res_cnt;
    logic               r_out_valid;
    logic [23:0]        r_out_data;

    logic               div_start;
    logic               div_done;
    logic [NEED_W-1:0]  div_need;
    logic               mem_wr;
    logic [W-1:0]       mem_wfree;
    logic [W-1:0]       mem_wcont;
    logic [W-1:0]       mem_rfree;
    logic [W-1:0]       mem_rcont;

    logic [W-1:0]       n_valid;
    logic               n_hit;
    logic [BW-1:0]      n_hit_b;
    logic [LW-1:0]      n_run;
    logic [W-1:0]       n_mark;
    logic [W-1:0]       n_fmask;
    logic [ZW-1:0]      n_z;
    logic [CW-1:0]      n_hit_end;
    logic [CW-1:0]      n_rem;
    logic [PW-1:0]      n_prod;
    logic               in_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign div_start     = in_acc && (s_axis_tuser[0] == OP_ALLOC);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    bffsa_div #(.DIVISOR(SLOT_BYTES)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (s_axis_tdata[15:0]),
        .o_done     (div_done),
        .o_need     (div_need)
    );

    bffsa_maps #(.DEPTH(MAP_WORDS), .AW(AW), .W(W)) u_maps (
        .i_clk     (i_clk),
        .i_addr    (r_w),
        .i_wr_en   (mem_wr),
        .i_wr_free (mem_wfree),
        .i_wr_cont (mem_wcont),
        .o_rd_free (mem_rfree),
        .o_rd_cont (mem_rcont)
    );

    // per-word scan, mark and free masks
    always_comb begin
        logic [LW-1:0] len;
        logic [LW-1:0] s;
        logic          zf;
        logic [BW-1:0] zp;
        logic [W-1:0]  f;
        logic [W-1:0]  cp;
        n_hit   = 1'b0;
        n_hit_b = '0;
        n_run   = '0;
        n_z     = ZW'(W);
        for (int b = 0; b < W; b++) begin
            s          = LW'(r_base) + LW'(b);
            n_valid[b] = (s < LW'(SLOT_TOTAL));
            n_mark[b]  = (s >= LW'(r_start)) && (s <= LW'(r_end));
        end
        f  = mem_rfree & n_valid;
        for (int b = 0; b < W; b++) begin
            zf = 1'b0;
            zp = '0;
            for (int j = 0; j <= b; j++) begin
                if (!f[j]) begin
                    zf = 1'b1;
                    zp = BW'(j);
                end
            end
            len = zf ? (LW'(b) - LW'(zp)) : (r_run + LW'(b) + LW'(1));
            if (!n_hit && (len >= LW'(r_need))) begin
                n_hit   = 1'b1;
                n_hit_b = BW'(b);
            end
            if (b == W - 1) begin
                n_run = len;
            end
        end
        for (int b = 0; b < W; b++) begin
            cp[b] = (mem_rcont[b] || (r_first && (BW'(b) == r_b0))) && n_valid[b];
        end
        for (int b = W - 1; b >= 0; b--) begin
            if ((BW'(b) >= r_b0) && !cp[b]) begin
                n_z = ZW'(b);
            end
        end
        for (int b = 0; b < W; b++) begin
            n_fmask[b] = (BW'(b) >= r_b0) && (ZW'(b) < n_z);
        end
        n_hit_end = r_base + CW'(n_hit_b);
        n_prod    = PW'(r_slot) * PW'(RECIP);
        n_rem     = CW'(r_slot) - CW'(r_q) * CW'(W);
    end

    always_comb begin
        mem_wr    = 1'b0;
        mem_wfree = '1;
        mem_wcont = '0;
        case (r_state)
            ST_CLR: begin
                mem_wr = 1'b1;
            end
            ST_MARK_WR: begin
                mem_wr    = 1'b1;
                mem_wfree = mem_rfree & ~n_mark;
                for (int b = 0; b < W; b++) begin
                    mem_wcont[b] = n_mark[b] ? ((r_base + CW'(b)) != r_start)
                                             : mem_rcont[b];
                end
            end
            ST_FREE_WR: begin
                mem_wr    = 1'b1;
                mem_wfree = mem_rfree | n_fmask;
                mem_wcont = mem_rcont & ~n_fmask;
            end
            default: begin
                mem_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_w         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    if (r_w == AW'(MAP_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_w <= r_w + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_slot     <= s_axis_tdata[25:16];
                        r_res_ok   <= 1'b0;
                        r_res_slot <= '0;
                        r_res_cnt  <= '0;
                        if (s_axis_tuser[0] == OP_ALLOC) begin
                            r_state <= ST_DIV;
                        end else if (17'(s_axis_tdata[25:16]) >= 17'(SLOT_TOTAL)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_FDIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (div_need == '0 || div_need > NEED_W'(SLOT_TOTAL)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_need  <= CW'(div_need);
                            r_w     <= '0;
                            r_base  <= '0;
                            r_run   <= '0;
                            r_state <= ST_SRCH_RD;
                        end
                    end
                end
                ST_SRCH_RD: begin
                    r_state <= ST_SRCH_EX;
                end
                ST_SRCH_EX: begin
                    if (n_hit) begin
                        r_end      <= n_hit_end;
                        r_start    <= n_hit_end - r_need + CW'(1);
                        r_res_ok   <= 1'b1;
                        r_res_slot <= n_hit_end - r_need + CW'(1);
                        r_res_cnt  <= r_need;
                        r_state    <= ST_MARK_RD;
                    end else if (r_w == AW'(MAP_WORDS - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_w     <= r_w + 1'b1;
                        r_base  <= r_base + CW'(W);
                        r_run   <= n_run;
                        r_state <= ST_SRCH_RD;
                    end
                end
                ST_MARK_RD: begin
                    r_state <= ST_MARK_WR;
                end
                ST_MARK_WR: begin
                    if (r_base <= r_start) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_w     <= r_w - 1'b1;
                        r_base  <= r_base - CW'(W);
                        r_state <= ST_MARK_RD;
                    end
                end
                ST_FDIV: begin
                    r_q     <= AW'(n_prod >> 16);
                    r_state <= ST_FFIX;
                end
                ST_FFIX: begin
                    if (n_rem >= CW'(W)) begin
                        r_w    <= r_q + 1'b1;
                        r_b0   <= BW'(n_rem - CW'(W));
                        r_base <= CW'(r_slot) - (n_rem - CW'(W));
                    end else begin
                        r_w    <= r_q;
                        r_b0   <= BW'(n_rem);
                        r_base <= CW'(r_slot) - n_rem;
                    end
                    r_first <= 1'b1;
                    r_cnt   <= '0;
                    r_state <= ST_FREE_RD;
                end
                ST_FREE_RD: begin
                    r_state <= ST_FREE_WR;
                end
                ST_FREE_WR: begin
                    if (n_z == ZW'(W) && r_w != AW'(MAP_WORDS - 1)) begin
                        r_cnt   <= r_cnt + CW'(n_z) - CW'(r_b0);
                        r_w     <= r_w + 1'b1;
                        r_base  <= r_base + CW'(W);
                        r_b0    <= '0;
                        r_first <= 1'b0;
                        r_state <= ST_FREE_RD;
                    end else begin
                        r_res_ok  <= 1'b1;
                        r_res_cnt <= r_cnt + CW'(n_z) - CW'(r_b0);
                        r_state   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {2'b00, COUNT_W'(r_res_cnt),
                                        SLOT_W'(r_res_slot), r_res_ok};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: tb/bitmap_first_fit_slot_allocator_test.sv
`timescale 1ns / 1ps
module bitmap_first_fit_slot_allocator_test;
    import bffsa_pkg::*;

    localparam int POOL_SLOTS = 1024;
    localparam int SLOT_SIZE  = 4;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  granted;
        logic             ok;
    } t_grant;

    typedef struct {
        logic             op;
        logic [BYTES_W-1:0] req_bytes;
        logic [SLOT_W-1:0]  slot;
        bit               typed;
        t_grant           want;
    } t_order;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [31:0] s_axis_tdata;   // request_bytes, start_slot
    logic [0:0]  s_axis_tuser;   // op
    logic m_axis_tvalid, m_axis_tready;
    logic [23:0] m_axis_tdata;   // ok, granted_slot, slot_count

    bitmap_first_fit_slot_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    bit     slot_free [POOL_SLOTS];
    bit     slot_cont [POOL_SLOTS];
    t_grant pending_grants[$];
    int     errors = 0;
    int     cycles = 0;
    bit     hold_off = 0;
    t_order plan[$];

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_grant model_alloc(logic [BYTES_W-1:0] nbytes);
        t_grant g;
        int need, run, i, start;
        g = '0;
        need = (nbytes + SLOT_SIZE - 1) / SLOT_SIZE;
        if (need == 0 || need > POOL_SLOTS) return g;
        run = 0;
        for (i = 0; i < POOL_SLOTS; i++) begin
            run = slot_free[i] ? run + 1 : 0;
            if (run == need) break;
        end
        if (run != need) return g;
        start = i + 1 - need;
        for (i = start; i < start + need; i++) begin
            slot_free[i] = 0;
            slot_cont[i] = (i != start);
        end
        g.ok = 1;
        g.granted = start[SLOT_W-1:0];
        g.count = need[COUNT_W-1:0];
        return g;
    endfunction

    function automatic t_grant model_release(logic [SLOT_W-1:0] first);
        t_grant g;
        int s, n;
        g = '0;
        s = int'(first);
        n = 0;
        do begin
            slot_free[s] = 1;
            slot_cont[s] = 0;
            n++;
            s++;
        end while (s < POOL_SLOTS && slot_cont[s]);
        g.ok = 1;
        g.count = n[COUNT_W-1:0];
        return g;
    endfunction

    task automatic send_order(t_order o);
        t_grant g;
        int gap;
        gap = $urandom_range(0, 18);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        g = (o.op == OP_ALLOC) ? model_alloc(o.req_bytes) : model_release(o.slot);
        if (o.typed && g !== o.want) begin
            errors++;
            if (errors <= 10)
                $display("directed row mismatch: typed %h model %h", o.want, g);
        end
        pending_grants.push_back(g);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= o.op;
        s_axis_tdata  <= {6'd0, o.slot, o.req_bytes};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender idles until every expected beat has come back
    task automatic drain();
        s_axis_tvalid <= 0;
        wait (pending_grants.size() == 0);
        @(negedge i_clk);
    endtask

    function automatic t_order mk(logic op, int b, int s, bit typed, t_grant w);
        t_order o;
        o.op = op; o.req_bytes = BYTES_W'(b); o.slot = SLOT_W'(s);
        o.typed = typed; o.want = w;
        return o;
    endfunction

    // receiver
    initial begin
        int gap;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 0;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (gap != 0) begin
                    m_axis_tready <= 0;
                    repeat (gap) @(negedge i_clk);
                end
                m_axis_tready <= 1;
                @(posedge i_clk);
                while (!m_axis_tvalid) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant got, exp_g;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[SLOT_W+COUNT_W:0];
            if (pending_grants.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", got);
            end else begin
                exp_g = pending_grants.pop_front();
                if (got !== exp_g || m_axis_tdata[23:22] !== 2'b00) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp ok=%0d slot=%0d cnt=%0d got ok=%0d slot=%0d cnt=%0d",
                                 exp_g.ok, exp_g.granted, exp_g.count,
                                 got.ok, got.granted, got.count);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("bitmap_first_fit_slot_allocator_test failed");
            $finish;
        end
    end

    initial begin
        int i, k, b, s;
        t_order o;
        t_grant w;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ALLOC;
        i_rst_n = 0;
        for (i = 0; i < POOL_SLOTS; i++) begin
            slot_free[i] = 1;
            slot_cont[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        w = '0;
        plan.push_back(mk(OP_ALLOC, 0, 1023, 1, w));
        plan.push_back(mk(OP_ALLOC, 4097, 0, 1, w));
        plan.push_back(mk(OP_ALLOC, 65535, 0, 1, w));
        w = '{ok: 1'b1, granted: 10'd0, count: 11'd1};
        plan.push_back(mk(OP_ALLOC, 1, 0, 1, w));
        w = '{ok: 1'b1, granted: 10'd1, count: 11'd2};
        plan.push_back(mk(OP_ALLOC, 5, 0, 0, w));
        plan.push_back(mk(OP_ALLOC, 8, 0, 0, w));
        plan.push_back(mk(OP_FREE, 65535, 1, 0, w));
        plan.push_back(mk(OP_FREE, 0, 1, 0, w));
        plan.push_back(mk(OP_ALLOC, 200, 0, 0, w));
        plan.push_back(mk(OP_FREE, 0, 0, 0, w));
        plan.push_back(mk(OP_FREE, 0, 3, 0, w));
        plan.push_back(mk(OP_FREE, 0, 1023, 0, w));
        plan.push_back(mk(OP_ALLOC, 4096, 0, 0, w));
        plan.push_back(mk(OP_FREE, 0, 1020, 0, w));
        plan.push_back(mk(OP_FREE, 0, 0, 0, w));
        plan.push_back(mk(OP_ALLOC, 4096, 0, 0, w));
        plan.push_back(mk(OP_FREE, 0, 0, 0, w));
        plan.push_back(mk(OP_ALLOC, 4092, 0, 0, w));
        plan.push_back(mk(OP_ALLOC, 4, 0, 0, w));
        plan.push_back(mk(OP_FREE, 0, 1023, 0, w));
        plan.push_back(mk(OP_FREE, 0, 0, 0, w));
        while (plan.size() > 0) send_order(plan.pop_front());

        // fill up the output while the receiver holds off
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            for (k = 0; k < 6; k++)
                send_order(mk(OP_ALLOC, $urandom_range(1, 64), 0, 0, w));
        join
        drain();

        for (k = 0; k < 480; k++) begin
            if (k == 240) drain();
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 5))
                    0: b = $urandom_range(0, 65535);
                    1: b = $urandom_range(1000, 4096);
                    default: b = $urandom_range(1, 160);
                endcase
                send_order(mk(OP_ALLOC, b, $urandom_range(0, 1023), 0, w));
            end else begin
                s = $urandom_range(0, 1023);
                for (i = 0; i < 64; i++) begin
                    if (!slot_free[s] && !slot_cont[s]) break;
                    s = $urandom_range(0, 1023);
                end
                send_order(mk(OP_FREE, $urandom_range(0, 65535), s, 0, w));
            end
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("bitmap_first_fit_slot_allocator_test passed");
        else
            $display("bitmap_first_fit_slot_allocator_test failed");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/bffsa_pkg.sv
hw/rtl/bffsa_div.sv
hw/rtl/bffsa_maps.sv
hw/rtl/bitmap_first_fit_slot_allocator.sv
tb/bitmap_first_fit_slot_allocator_test.sv
